// ===== design/ybgra_pkg.sv =====
package ybgra_pkg;

    // Signed working width for all weighted sums (range about -71k..137k)
    localparam int SUM_W = 20;

    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_sum COEF_Y  = 20'sd298;
    localparam t_sum COEF_RV = 20'sd409;
    localparam t_sum COEF_GU = 20'sd100;
    localparam t_sum COEF_GV = 20'sd208;
    localparam t_sum COEF_BU = 20'sd516;
    localparam t_sum LUMA_OFS   = 20'sd16;
    localparam t_sum CHROMA_OFS = 20'sd128;
    localparam t_sum ROUND_OFS  = 20'sd128;
    localparam logic [7:0] CHAN_MAX = 8'd255;

    localparam int LANES = 4;

    localparam logic [2:0] COUNT_YUY2 = 3'd2;
    localparam logic [2:0] COUNT_NV12 = 3'd4;

    localparam logic FMT_YUY2 = 1'b0;
    localparam logic FMT_NV12 = 1'b1;

    // Pipeline enables shared by all stages
    typedef struct packed {
        logic en_s1;
        logic en_s2;
    } t_pipe_ctrl;

    // Chroma contributions, rounding constant already folded in
    typedef struct packed {
        t_sum red;
        t_sum green;
        t_sum blue;
    } t_chroma_terms;

endpackage

// ===== design/ybgra_chroma.sv =====
module ybgra_chroma (
    input  logic                    i_clk,
    input  ybgra_pkg::t_pipe_ctrl   i_ctrl,
    input  logic [7:0]              i_cb,
    input  logic [7:0]              i_cr,
    output ybgra_pkg::t_chroma_terms o_terms
);
    import ybgra_pkg::*;

    t_sum          w_d;
    t_sum          w_e;
    t_chroma_terms n_terms;
    t_chroma_terms r_terms;

    always_comb begin
        w_d = t_sum'({12'd0, i_cb}) - CHROMA_OFS;
        w_e = t_sum'({12'd0, i_cr}) - CHROMA_OFS;
        n_terms.red   = COEF_RV * w_e + ROUND_OFS;
        n_terms.green = ROUND_OFS - COEF_GU * w_d - COEF_GV * w_e;
        n_terms.blue  = COEF_BU * w_d + ROUND_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s1) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ===== design/ybgra_lane.sv =====
module ybgra_lane (
    input  logic                     i_clk,
    input  ybgra_pkg::t_pipe_ctrl    i_ctrl,
    input  logic [7:0]               i_luma,
    input  ybgra_pkg::t_chroma_terms i_terms,
    output logic [31:0]              o_pixel
);
    import ybgra_pkg::*;

    t_sum       w_c;
    t_sum       n_y_term;
    t_sum       r_y_term;
    t_sum       w_sum_r;
    t_sum       w_sum_g;
    t_sum       w_sum_b;
    logic [7:0] w_r;
    logic [7:0] w_g;
    logic [7:0] w_b;

    function automatic logic [7:0] clamp_chan(input t_sum sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (sum[SUM_W-2:16] != '0) begin
            res = CHAN_MAX;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    always_comb begin
        w_c      = t_sum'({12'd0, i_luma}) - LUMA_OFS;
        n_y_term = COEF_Y * w_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s1) begin
            r_y_term <= n_y_term;
        end
    end

    always_comb begin
        w_sum_r = r_y_term + i_terms.red;
        w_sum_g = r_y_term + i_terms.green;
        w_sum_b = r_y_term + i_terms.blue;
        w_r     = clamp_chan(w_sum_r);
        w_g     = clamp_chan(w_sum_g);
        w_b     = clamp_chan(w_sum_b);
    end

    // alpha stays zero
    assign o_pixel = {8'd0, w_r, w_g, w_b};

endmodule

// ===== design/ybgra_merge.sv =====
module ybgra_merge (
    input  logic                  i_clk,
    input  ybgra_pkg::t_pipe_ctrl i_ctrl,
    input  logic                  i_format,
    input  logic [31:0]           i_pixel [ybgra_pkg::LANES],
    output logic [135:0]          o_tdata
);
    import ybgra_pkg::*;

    logic [135:0] n_data;
    logic [135:0] r_data;

    always_comb begin
        n_data         = '0;
        n_data[31:0]   = i_pixel[0];
        n_data[63:32]  = i_pixel[1];
        if (i_format == FMT_NV12) begin
            n_data[95:64]   = i_pixel[2];
            n_data[127:96]  = i_pixel[3];
            n_data[130:128] = COUNT_NV12;
        end else begin
            n_data[130:128] = COUNT_YUY2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_s2) begin
            r_data <= n_data;
        end
    end

    assign o_tdata = r_data;

endmodule

// ===== design/ycbcr_to_bgra_converter.sv =====
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid/tready/tdata[47:0]        lumas 0..3, Cb, Cr
// m_axis    out  tvalid/tready/tdata[135:0]       pixels 0..3, pixel count
// cfg       in   cfg_we/cfg_data                  pixel format
//
// One beat per clock sustained while the output is not stalled.
// Stage 1 registers the luma products and the shared chroma terms; stage 2
// adds, clamps and registers the merged result in the output register.
// A stalled output holds stage 2, and stage 1 when it is full; input ready follows the free slots.
// Synchronous active-low reset clears the valid bits and the format.
module ycbcr_to_bgra_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // luma_0[7:0], luma_1[15:8], luma_2[23:16], luma_3[31:24],
    // chroma_blue[39:32], chroma_red[47:40]
    input  logic [47:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pixel_0[31:0], pixel_1[63:32], pixel_2[95:64], pixel_3[127:96],
    // pixel_count[130:128], zero pad[135:131]
    output logic [135:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_data
);
    import ybgra_pkg::*;

    logic          r_format;
    logic          r_v1;
    logic          r_v2;
    logic          r_fmt1;
    logic          w_accept;
    t_pipe_ctrl    w_ctrl;
    t_chroma_terms w_terms;
    logic [31:0]   w_pixel [LANES];

    always_comb begin
        w_ctrl.en_s2    = !r_v2 || i_m_axis_tready;
        w_ctrl.en_s1    = !r_v1 || w_ctrl.en_s2;
        o_s_axis_tready = w_ctrl.en_s1;
        w_accept        = i_s_axis_tvalid && w_ctrl.en_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_YUY2;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_format <= i_cfg_data;
            end
            if (w_ctrl.en_s1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_ctrl.en_s2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // format travels with the beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fmt1 <= r_format;
        end
    end

    ybgra_chroma u_chroma (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_cb    (i_s_axis_tdata[39:32]),
        .i_cr    (i_s_axis_tdata[47:40]),
        .o_terms (w_terms)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ybgra_lane u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_luma  (i_s_axis_tdata[g*8 +: 8]),
            .i_terms (w_terms),
            .o_pixel (w_pixel[g])
        );
    end

    ybgra_merge u_merge (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_format (r_fmt1),
        .i_pixel  (w_pixel),
        .o_tdata  (o_m_axis_tdata)
    );

    assign o_m_axis_tvalid = r_v2;

endmodule

// ===== verif/tb_ycbcr_to_bgra_converter.sv =====
`timescale 1ns / 100ps

module tb_ycbcr_to_bgra_converter;
    import ybgra_pkg::*;

    localparam int  RAND_PHASES   = 6;
    localparam int  PHASE_ITEMS   = 305;
    localparam int  LONG_HOLD     = 80;
    localparam int  HOLD_AT_A     = 500;
    localparam int  HOLD_AT_B     = 1400;
    localparam int  DRAIN_CYCLES  = 4;
    localparam int  CYCLE_LIMIT   = 300000;

    // Field order runs from the top bit down, so chroma_red lands in [47:40]
    typedef struct packed {
        logic [7:0] cr;
        logic [7:0] cb;
        logic [7:0] y3;
        logic [7:0] y2;
        logic [7:0] y1;
        logic [7:0] y0;
    } t_ycc_group;

    typedef struct packed {
        logic [2:0]  count;
        logic [31:0] px3;
        logic [31:0] px2;
        logic [31:0] px1;
        logic [31:0] px0;
    } t_bgra_beat;

    typedef struct {
        logic       fmt;
        t_ycc_group grp;
        bit         pinned;
        t_bgra_beat beat;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // luma_0[7:0], luma_1[15:8], luma_2[23:16], luma_3[31:24],
    // chroma_blue[39:32], chroma_red[47:40]
    logic [47:0]  i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // pixel_0[31:0], pixel_1[63:32], pixel_2[95:64], pixel_3[127:96],
    // pixel_count[130:128], zero pad[135:131]
    logic [135:0] o_m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_data = 1'b0;

    logic         fmt_model = FMT_YUY2;
    bit           burst_mode = 1'b0;
    int           err_cnt = 0;
    int           cycle_cnt = 0;
    t_bgra_beat   offered_q[$];
    t_bgra_beat   bgra_expect_q[$];
    t_dir_row     dir_rows[$];
    logic         phase_fmt[RAND_PHASES];

    ycbcr_to_bgra_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] clamp_chan(int sum);
        if (sum < 0)
            return 8'd0;
        if ((sum >> 8) > 255)
            return 8'd255;
        return sum[15:8];
    endfunction

    function automatic logic [31:0] bgra_of(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
        int c;
        int d;
        int e;
        c = int'(y) - 16;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        return {8'h00,
                clamp_chan(298 * c + 409 * e + 128),
                clamp_chan(298 * c - 100 * d - 208 * e + 128),
                clamp_chan(298 * c + 516 * d + 128)};
    endfunction

    function automatic t_bgra_beat convert_group(t_ycc_group g, logic fmt);
        t_bgra_beat r;
        r.px0 = bgra_of(g.y0, g.cb, g.cr);
        r.px1 = bgra_of(g.y1, g.cb, g.cr);
        if (fmt == FMT_NV12) begin
            r.px2   = bgra_of(g.y2, g.cb, g.cr);
            r.px3   = bgra_of(g.y3, g.cb, g.cr);
            r.count = COUNT_NV12;
        end else begin
            r.px2   = '0;
            r.px3   = '0;
            r.count = COUNT_YUY2;
        end
        return r;
    endfunction

    // Lean toward the clamp edges and the luma offset without losing full coverage
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 20));
            3: return 8'($urandom_range(230, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_ycc_group random_group();
        t_ycc_group g;
        g.y0 = pick_sample();
        g.y1 = pick_sample();
        g.y2 = pick_sample();
        g.y3 = pick_sample();
        g.cb = pick_sample();
        g.cr = pick_sample();
        return g;
    endfunction

    task automatic add_row(logic fmt, logic [7:0] y0, logic [7:0] y1, logic [7:0] y2,
                           logic [7:0] y3, logic [7:0] cb, logic [7:0] cr,
                           bit pinned = 1'b0, logic [31:0] p0 = '0, logic [31:0] p1 = '0,
                           logic [31:0] p2 = '0, logic [31:0] p3 = '0);
        t_dir_row row;
        row.fmt        = fmt;
        row.grp        = '{cr: cr, cb: cb, y3: y3, y2: y2, y1: y1, y0: y0};
        row.pinned     = pinned;
        row.beat.px0   = p0;
        row.beat.px1   = p1;
        row.beat.px2   = p2;
        row.beat.px3   = p3;
        row.beat.count = (fmt == FMT_NV12) ? COUNT_NV12 : COUNT_YUY2;
        dir_rows.push_back(row);
    endtask

    task automatic offer_group(t_ycc_group grp, t_bgra_beat want);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_q.push_back(want);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= grp;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        i_s_axis_tvalid <= 1'b0;
        while (offered_q.size() != 0 || bgra_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(logic fmt);
        drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= fmt;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        fmt_model = fmt;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Move the expectation into the result store on each accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            bgra_expect_q.push_back(offered_q.pop_front());
    end

    always @(posedge i_clk) begin : out_check
        t_bgra_beat want;
        t_bgra_beat got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[130:0];
            if (bgra_expect_q.size() == 0) begin
                $error("output beat with no expectation waiting: %h", got);
                err_cnt++;
            end else begin
                want = bgra_expect_q.pop_front();
                check_field("pixel_0", want.px0, got.px0);
                check_field("pixel_1", want.px1, got.px1);
                check_field("pixel_2", want.px2, got.px2);
                check_field("pixel_3", want.px3, got.px3);
                check_field("pixel_count", 32'(want.count), 32'(got.count));
            end
        end
    end

    // Output side: random stall per beat, none in burst phases, two long hold-offs
    initial begin : rx_side
        int stall;
        int rx_beats;
        rx_beats = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_beats == HOLD_AT_A || rx_beats == HOLD_AT_B)
                stall = LONG_HOLD;
            else
                stall = burst_mode ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid)
                @(posedge i_clk);
            rx_beats++;
        end
    end

    initial begin : tx_side
        t_ycc_group grp;
        t_bgra_beat want;
        phase_fmt = '{FMT_NV12, FMT_YUY2, FMT_NV12, FMT_NV12, FMT_YUY2, FMT_NV12};

        // Clamp points: Y=16 with neutral chroma gives black, Y>=235 saturates
        // to white, Y below 16 floors to zero; full-scale chroma drives one
        // channel high and the others to zero.
        add_row(FMT_YUY2, 8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128, 1'b1,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128, 1'b1,
                32'h00FFFFFF, 32'h00FFFFFF, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd255, 8'd0, 8'd255, 8'd255, 8'd128, 8'd128, 1'b1,
                32'h00FFFFFF, 32'h0, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd16, 8'd16, 8'd77, 8'd200, 8'd255, 8'd128, 1'b1,
                32'h000000FF, 32'h000000FF, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd16, 8'd16, 8'd0, 8'd255, 8'd128, 8'd255, 1'b1,
                32'h00CB0000, 32'h00CB0000, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd16, 8'd16, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1,
                32'h00009A00, 32'h00009A00, 32'h0, 32'h0);
        add_row(FMT_YUY2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_row(FMT_YUY2, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_row(FMT_YUY2, 8'd81, 8'd145, 8'd170, 8'd85, 8'd90, 8'd240);
        add_row(FMT_NV12, 8'd16, 8'd235, 8'd0, 8'd255, 8'd128, 8'd128, 1'b1,
                32'h0, 32'h00FFFFFF, 32'h0, 32'h00FFFFFF);
        add_row(FMT_NV12, 8'd16, 8'd16, 8'd16, 8'd16, 8'd255, 8'd128, 1'b1,
                32'h000000FF, 32'h000000FF, 32'h000000FF, 32'h000000FF);
        add_row(FMT_NV12, 8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd255, 1'b1,
                32'h00CB0000, 32'h00CB0000, 32'h00CB0000, 32'h00CB0000);
        add_row(FMT_NV12, 8'd16, 8'd16, 8'd16, 8'd16, 8'd0, 8'd0, 1'b1,
                32'h00009A00, 32'h00009A00, 32'h00009A00, 32'h00009A00);
        add_row(FMT_NV12, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_row(FMT_NV12, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_row(FMT_NV12, 8'd128, 8'd64, 8'd192, 8'd32, 8'd0, 8'd255);
        add_row(FMT_NV12, 8'd128, 8'd64, 8'd192, 8'd32, 8'd255, 8'd0);
        add_row(FMT_NV12, 8'd1, 8'd2, 8'd254, 8'd253, 8'd127, 8'd129);
        add_row(FMT_YUY2, 8'd200, 8'd50, 8'd170, 8'd85, 8'd85, 8'd170);
        add_row(FMT_YUY2, 8'd235, 8'd16, 8'd0, 8'd0, 8'd128, 8'd128, 1'b1,
                32'h00FFFFFF, 32'h0, 32'h0, 32'h0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_format(FMT_YUY2);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].fmt != fmt_model)
                set_format(dir_rows[i].fmt);
            want = dir_rows[i].pinned ? dir_rows[i].beat
                                      : convert_group(dir_rows[i].grp, fmt_model);
            offer_group(dir_rows[i].grp, want);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            set_format(phase_fmt[phase]);
            burst_mode = (phase == 1 || phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                grp = random_group();
                offer_group(grp, convert_group(grp, fmt_model));
            end
        end

        burst_mode = 1'b0;
        drain_pipe();
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ybgra_pkg.sv
design/ybgra_chroma.sv
design/ybgra_lane.sv
design/ybgra_merge.sv
design/ycbcr_to_bgra_converter.sv
verif/tb_ycbcr_to_bgra_converter.sv
